@@ design/spq_pkg.sv @@
package spq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Contents of one cell.
    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] prio;
    } t_slot;

    // Command broadcast to every cell.
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] prio;
    } t_ctrl;

endpackage

@@ design/sorted_priority_queue.sv @@
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_op, i_element, i_priority_req
// result    out        o_valid / i_ready    o_out_element, o_status, o_occupancy
//
// One request per cycle while the output register is free or drains; its result
// appears in the output register the following cycle. The insert or shift is
// registered with it across the cell chain: every cell compares its own priority with
// the request in parallel. Reset empties the chain at once; no clearing pass is needed.
// A stalled result holds the output register; a new request is taken only
// when that register is empty or is being drained in the same cycle.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic signed [31:0] i_element,
    input  logic signed [31:0] i_priority_req,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_element,
    output logic [1:0]         o_status,
    output logic [4:0]         o_occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_out_element;
    logic signed [DATA_W-1:0] n_out_element;
    t_status                  r_status;
    t_status                  n_status;
    logic [OCC_W-1:0]         r_occupancy;

    logic   w_accept;
    logic   w_full;
    logic   w_empty;
    t_ctrl  w_ctrl;
    t_slot  w_slot [CAPACITY];
    logic   w_d    [CAPACITY];

    // Take a request when the output register is free or drains now.
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Decode the request and gate off rejected operations.
    always_comb begin
        w_ctrl.enq    = w_accept && (i_op == OP_ENQ) && !w_full;
        w_ctrl.deq    = w_accept && (i_op == OP_DEQ) && !w_empty;
        w_ctrl.elem   = i_element;
        w_ctrl.prio   = i_priority_req;
        n_count       = r_count;
        n_out_element = '0;
        n_status      = ST_DONE;
        if (i_op == OP_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count       = r_count - 1'b1;
                n_out_element = w_slot[0].elem;
            end
        end
    end

    // Head of the chain sits in cell 0; entries shift right on insert, left on removal.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_d;

        if (i == 0) begin : g_head
            assign w_left   = '0;
            assign w_left_d = 1'b0;
        end else begin : g_body
            assign w_left   = w_slot[i-1];
            assign w_left_d = w_d[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_slot[i+1];
        end

        spq_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_left   (w_left),
            .i_left_d (w_left_d),
            .i_right  (w_right),
            .o_slot   (w_slot[i]),
            .o_d      (w_d[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_element <= n_out_element;
            r_status      <= n_status;
            r_occupancy   <= OCC_W'(n_count);
        end
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_out_element = r_out_element;
    assign o_status      = r_status;
    assign o_occupancy   = r_occupancy;

endmodule

@@ design/spq_cell.sv @@
module spq_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_ctrl i_ctrl,
    input  spq_pkg::t_slot i_left,
    input  logic          i_left_d,
    input  spq_pkg::t_slot i_right,
    output spq_pkg::t_slot o_slot,
    output logic          o_d
);
    import spq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // Insert point or later: empty, or strictly lower priority than the request.
    assign o_d    = !r_slot.occ || (r_slot.prio < i_ctrl.prio);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.enq) begin
            if (o_d && i_left_d) begin
                n_slot = i_left;
            end else if (o_d) begin
                n_slot.occ  = 1'b1;
                n_slot.elem = i_ctrl.elem;
                n_slot.prio = i_ctrl.prio;
            end
        end else if (i_ctrl.deq) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.elem <= n_slot.elem;
        r_slot.prio <= n_slot.prio;
        if (!i_rst_n) begin
            r_slot.occ <= 1'b0;
        end else begin
            r_slot.occ <= n_slot.occ;
        end
    end

endmodule
